/* rtl/bba_pkg.sv */
// Shared types, constants and helpers for the block bitmap allocator.
// Used by the controller, the datapath, the top level and the checker.
package bba_pkg;

   // Field widths
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int WORD_W = 32;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int WA_W   = CNT_W - BIT_W;

   // Block count limits
   localparam int MAX_BLOCKS_DEF = 1024;
   localparam int RST_BLOCKS     = 1024;
   localparam int CNT_MAX        = (1 << CNT_W) - 1;

   typedef enum logic [1:0] {
      MODE_CHECK   = 2'd0,
      MODE_CLAIM   = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_FIND    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FOUND_ZERO  = 2'd0,
      FOUND_COUNT = 2'd1,
      FOUND_SCAN  = 2'd2
   } found_sel_type;

   typedef struct packed {
      mode_type          mode;
      logic [IDX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [CNT_W-1:0]  found_index;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  lowest_free;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic          cfg_load;
      logic          clear_wr;
      logic          capture;
      logic          map_set;
      logic          map_clr;
      logic          cnt_dec;
      logic          cnt_inc;
      logic          hint_lower;
      logic          scan_begin;
      logic          scan_from_next;
      logic          scan_rd;
      logic          hint_from_scan;
      logic          res_write;
      logic          res_err;
      found_sel_type found_sel;
      logic          rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      mode_type mode;
      logic     in_range;
      logic     bit_set;
      logic     at_hint;
      logic     scan_done;
      logic     clr_last;
   } sts_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } zero_pos_type;

   // Lowest clear bit of a map word
   function automatic zero_pos_type first_zero(input logic [WORD_W-1:0] w);
      zero_pos_type r;
      r.found = 1'b0;
      r.pos   = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r.found = 1'b1;
            r.pos   = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

/* rtl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No package dependencies.
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bba_datapath.sv */
// Datapath: allocation map RAM, counters, word scanner and result register.
// Depends on bba_pkg and bba_ram; driven by bba_ctrl through cmd_type.
module bba_datapath #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bba_pkg::cmd_type         cmd,
   output bba_pkg::sts_type         sts,
   input  bba_pkg::req_type         req_data,
   input  logic [bba_pkg::CNT_W-1:0] csr_data,
   output bba_pkg::rsp_type         rsp_data
);
   import bba_pkg::*;

   localparam int USE_BLOCKS = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
   localparam int RST_COUNT  = (RST_BLOCKS < USE_BLOCKS) ? RST_BLOCKS : USE_BLOCKS;
   localparam int NEED_WORDS = (USE_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int AW         = (NEED_WORDS > 1) ? $clog2(NEED_WORDS) : 1;
   localparam int DEPTH      = 1 << AW;

   // Control registers
   logic [CNT_W-1:0] bc_ff, free_ff, hint_ff;
   logic [WA_W-1:0]  clr_ff, rd_ff, ev_word_ff;
   logic             ev_valid_ff;
   // Payload registers
   mode_type         mode_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] start_ff;
   logic             res_err_ff;
   logic [CNT_W-1:0] res_found_ff;
   rsp_type          rsp_ff;

   logic [WORD_W-1:0] rd_data, wr_data, bit_onehot, low_mask;
   logic [AW-1:0]     ram_raddr, ram_waddr;
   logic              ram_we;
   logic [CNT_W-1:0]  idx_ext, bc_m1, scan_start_in, cand, scan_res, cfg_val;
   logic [WA_W-1:0]   idx_word, last_word;
   logic [BIT_W-1:0]  idx_bit;
   zero_pos_type      fz;
   logic              hit, word_ok;

   // Address decode of the item
   assign idx_ext    = CNT_W'(idx_ff);
   assign idx_word   = WA_W'(idx_ff[IDX_W-1:BIT_W]);
   assign idx_bit    = idx_ff[BIT_W-1:0];
   assign bit_onehot = WORD_W'(1) << idx_bit;
   assign bc_m1      = bc_ff - CNT_W'(1);
   assign last_word  = bc_m1[CNT_W-1:BIT_W];

   // Clamp the written block count
   always_comb begin
      if (csr_data == '0) begin
         cfg_val = CNT_W'(1);
      end else if (32'(csr_data) > 32'(USE_BLOCKS)) begin
         cfg_val = CNT_W'(USE_BLOCKS);
      end else begin
         cfg_val = csr_data;
      end
   end

   // Scan: mask bits below the start, take lowest clear bit
   assign scan_start_in = cmd.scan_from_next ? (idx_ext + CNT_W'(1)) : idx_ext;
   assign low_mask = (ev_word_ff == start_ff[CNT_W-1:BIT_W]) ?
                     ((WORD_W'(1) << start_ff[BIT_W-1:0]) - WORD_W'(1)) : '0;
   assign fz       = first_zero(rd_data | low_mask);
   assign cand     = {ev_word_ff, fz.pos};
   assign word_ok  = (ev_word_ff <= last_word);
   assign hit      = word_ok && fz.found && (cand < bc_ff);
   assign scan_res = hit ? cand : bc_ff;

   // RAM ports
   assign ram_raddr = cmd.scan_rd ? AW'(rd_ff) : AW'(idx_word);
   assign ram_we    = cmd.clear_wr | cmd.map_set | cmd.map_clr;
   assign ram_waddr = cmd.clear_wr ? AW'(clr_ff) : AW'(idx_word);
   always_comb begin
      if (cmd.clear_wr) begin
         wr_data = '0;
      end else if (cmd.map_set) begin
         wr_data = rd_data | bit_onehot;
      end else begin
         wr_data = rd_data & ~bit_onehot;
      end
   end

   bba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (wr_data),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   // Status back to the controller
   always_comb begin
      sts.mode      = mode_ff;
      sts.in_range  = (idx_ext < bc_ff);
      sts.bit_set   = rd_data[idx_bit];
      sts.at_hint   = (idx_ext == hint_ff);
      sts.scan_done = ev_valid_ff && (hit || (ev_word_ff >= last_word));
      sts.clr_last  = (clr_ff == last_word);
   end

   // Counters, hint and scan pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff       <= CNT_W'(RST_COUNT);
         free_ff     <= CNT_W'(RST_COUNT);
         hint_ff     <= '0;
         clr_ff      <= '0;
         rd_ff       <= '0;
         ev_word_ff  <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_load) begin
            bc_ff   <= cfg_val;
            free_ff <= cfg_val;
            hint_ff <= '0;
            clr_ff  <= '0;
         end else begin
            if (cmd.clear_wr) begin
               clr_ff <= clr_ff + WA_W'(1);
            end
            if (cmd.cnt_dec && (free_ff != '0)) begin
               free_ff <= free_ff - CNT_W'(1);
            end
            if (cmd.cnt_inc && (free_ff < bc_ff)) begin
               free_ff <= free_ff + CNT_W'(1);
            end
            if (cmd.hint_lower && (idx_ext < hint_ff)) begin
               hint_ff <= idx_ext;
            end
            if (cmd.hint_from_scan) begin
               hint_ff <= scan_res;
            end
         end
         if (cmd.scan_begin) begin
            rd_ff       <= scan_start_in[CNT_W-1:BIT_W];
            ev_valid_ff <= 1'b0;
         end else if (cmd.scan_rd) begin
            rd_ff       <= rd_ff + WA_W'(1);
            ev_word_ff  <= rd_ff;
            ev_valid_ff <= 1'b1;
         end
      end
   end

   // Item, result and output payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_data.mode;
         idx_ff  <= req_data.block_index;
      end
      if (cmd.scan_begin) begin
         start_ff <= scan_start_in;
      end
      if (cmd.res_write) begin
         res_err_ff <= cmd.res_err;
         case (cmd.found_sel)
            FOUND_COUNT: res_found_ff <= bc_ff;
            FOUND_SCAN:  res_found_ff <= scan_res;
            default:     res_found_ff <= '0;
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= res_err_ff;
         rsp_ff.found_index <= res_found_ff;
         rsp_ff.free_count  <= free_ff;
         rsp_ff.lowest_free <= hint_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/bba_ctrl.sv */
// Controller: sequences map clearing, lookup, update, scan and result hand-off.
// Depends on bba_pkg; talks to bba_datapath through cmd_type and sts_type.
module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_valid,
   output logic             csr_ready,
   output bba_pkg::cmd_type cmd,
   input  bba_pkg::sts_type sts
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_EVAL,
      S_SCAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;

      // Drop the result once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.res_write = 1'b1;
            state_in      = S_DONE;
            case (sts.mode)
               MODE_CHECK: begin
                  cmd.res_err = !(sts.in_range && sts.bit_set);
               end
               MODE_CLAIM: begin
                  cmd.res_err = !(sts.in_range && !sts.bit_set);
                  if (sts.in_range && !sts.bit_set) begin
                     cmd.map_set = 1'b1;
                     cmd.cnt_dec = 1'b1;
                     if (sts.at_hint) begin
                        cmd.scan_begin     = 1'b1;
                        cmd.scan_from_next = 1'b1;
                        state_in           = S_SCAN;
                     end
                  end
               end
               MODE_RELEASE: begin
                  cmd.res_err = !(sts.in_range && sts.bit_set);
                  if (sts.in_range && sts.bit_set) begin
                     cmd.map_clr    = 1'b1;
                     cmd.cnt_inc    = 1'b1;
                     cmd.hint_lower = 1'b1;
                  end
               end
               MODE_FIND: begin
                  if (sts.in_range) begin
                     cmd.scan_begin = 1'b1;
                     state_in       = S_SCAN;
                  end else begin
                     cmd.res_err   = 1'b1;
                     cmd.found_sel = FOUND_COUNT;
                  end
               end
               default: begin
                  cmd.res_err = 1'b1;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DONE;
               if (sts.mode == MODE_CLAIM) begin
                  cmd.hint_from_scan = 1'b1;
               end else begin
                  cmd.res_write = 1'b1;
                  cmd.found_sel = FOUND_SCAN;
               end
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // A register write restarts the clearing sweep
      if (csr_valid) begin
         cmd.cfg_load = 1'b1;
         cmd.clear_wr = 1'b0;
         state_in     = S_CLEAR;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/block_bitmap_allocator_core.sv */
// Top level of the block bitmap allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_datapath (and bba_ram below it).
//
//   channel  direction  payload          transfer when
//   req_     in         req_type         req_valid & req_ready
//   rsp_     out        rsp_type         rsp_valid & rsp_ready
//   csr_     in         block_count[10:0] csr_valid & csr_ready
//
// Check, release and out-of-range items pass from transfer through S_LOOKUP,
// S_EVAL and S_DONE to the result. Claim of the hinted block and in-range find
// also scan in S_SCAN, reading 32-bit map words from the map RAM port one per
// cycle: up to 32 at 1024 blocks.
// Reset and each block_count write start a clearing sweep of
// ceil(block_count / 32) map words (32 at reset) with req_ready low.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken in.
module block_bitmap_allocator_core #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bba_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bba_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bba_pkg::CNT_W-1:0] csr_data
);
   import bba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/bba_checker.sv */
// Port-level checker for block_bitmap_allocator_core, bound to the top level.
// Depends on bba_pkg for the payload types.
module bba_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input bba_pkg::rsp_type          rsp_data
);
   import bba_pkg::*;

   logic [1:0] pend_ff, pend_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};

   // Track items taken in but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an outstanding item");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready && pend_in != 2'd3)
      else $error("more than one item in work beside a waiting result");

   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("item taken before the map was cleared");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (.*);
